@@ sv/vqdfl_pkg.sv @@
package vqdfl_pkg;

    // command codes
    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_SET   = 2'd2,
        CMD_CHAIN = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    localparam logic [15:0] FLAG_NEXT = 16'h0001;
    localparam logic [15:0] LINK_END  = 16'hFFFF;
    localparam logic [8:0]  RING_SIZE_RESET = 9'd256;

    // one descriptor table entry
    typedef struct packed {
        logic [63:0] addr;
        logic [31:0] len;
        logic [15:0] flags;
        logic [15:0] next;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic cfg_load;
        logic clear;
        logic accept;
        logic exec;
        logic walk;
    } dp_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic walk_more;
        logic clear_last;
    } dp_stat_t;

endpackage

@@ sv/virtqueue_descriptor_free_list_top.sv @@
// allocate, set and chain: done strobes after the start transfer, through the
// execute state and the done register; free chain: one table read and write per entry
// a new command is taken only when idle, once the last one is through
// reset and every size register write start a clearing pass over all table entries;
// busy stays high during it; results cannot be stalled by the receiver
module virtqueue_descriptor_free_list_top
    import vqdfl_pkg::*;
#(
    parameter int MAX_DESCRIPTORS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] index,
    input  logic [15:0] next_index,
    input  logic [63:0] buf_addr,
    input  logic [31:0] buf_len,
    input  logic [15:0] desc_flags_in,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  alloc_index,
    output logic [8:0]  free_count,
    output logic [8:0]  freed_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);

    dp_ctl_t  ctl;
    dp_stat_t stat;

    // sequencing of commands and the clearing pass
    vqdfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .stat      (stat),
        .ctl       (ctl),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .done      (done)
    );

    // descriptor table and free list
    vqdfl_dp #(
        .MAX_DESCRIPTORS(MAX_DESCRIPTORS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .index         (index),
        .next_index    (next_index),
        .buf_addr      (buf_addr),
        .buf_len       (buf_len),
        .desc_flags_in (desc_flags_in),
        .status        (status),
        .alloc_index   (alloc_index),
        .free_count    (free_count),
        .freed_count   (freed_count)
    );

endmodule

@@ sv/vqdfl_ram.sv @@
module vqdfl_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port, read returns old data on collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/vqdfl_ctrl.sv @@
module vqdfl_ctrl
    import vqdfl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     cfg_valid,
    input  dp_stat_t stat,
    output dp_ctl_t  ctl,
    output logic     busy,
    output logic     cfg_ready,
    output logic     done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLEAR,
        S_EXEC,
        S_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;
    logic   cfg_fire;
    logic   accept;

    // a command transfer takes precedence over a size write when idle
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = ((state_reg == S_IDLE) && !start) || (state_reg == S_CLEAR);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign accept    = start && !busy;

    // commands to the datapath
    assign ctl.cfg_load = cfg_fire;
    assign ctl.clear    = (state_reg == S_CLEAR);
    assign ctl.accept   = accept;
    assign ctl.exec     = (state_reg == S_EXEC);
    assign ctl.walk     = (state_reg == S_WALK);

    // next state
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EXEC, S_WALK:
            begin
                if (stat.walk_more)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_fire)
        begin
            state_next = S_CLEAR;
            done_next  = 1'b0;
        end
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;

endmodule

@@ sv/vqdfl_dp.sv @@
module vqdfl_dp
    import vqdfl_pkg::*;
#(
    parameter int MAX_DESCRIPTORS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  dp_ctl_t     ctl,
    output dp_stat_t    stat,
    input  logic [8:0]  cfg_data,
    input  logic [1:0]  cmd,
    input  logic [15:0] index,
    input  logic [15:0] next_index,
    input  logic [63:0] buf_addr,
    input  logic [31:0] buf_len,
    input  logic [15:0] desc_flags_in,
    output logic [1:0]  status,
    output logic [7:0]  alloc_index,
    output logic [8:0]  free_count,
    output logic [8:0]  freed_count
);

    localparam int AW = $clog2(MAX_DESCRIPTORS);
    localparam int NW = $clog2(MAX_DESCRIPTORS + 1);
    localparam int CW = (NW > 9) ? NW : 9;
    localparam int EW = $bits(entry_t);

    // configuration and list state
    logic [8:0]    ring_size_reg, ring_size_next;
    logic [15:0]   list_head_reg, list_head_next;
    logic [NW-1:0] free_total_reg, free_total_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    // latched command
    cmd_t          cmd_reg;
    logic [15:0]   idx_reg;
    logic [15:0]   nidx_reg;
    logic [63:0]   buf_addr_reg;
    logic [31:0]   buf_len_reg;
    logic [15:0]   flags_reg;

    // walk and result state
    logic [AW-1:0] cur_reg, cur_next;
    logic [NW-1:0] steps_reg, steps_next;
    logic [NW-1:0] freed_reg, freed_next;
    status_t       status_reg, status_next;
    logic [7:0]    alloc_reg, alloc_next;
    logic          fwd_hit_reg, fwd_hit_next;
    entry_t        fwd_data_reg;

    // table port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_raw;
    entry_t        rd_eff;

    // effective size
    logic [CW-1:0] qs_wide;
    logic [NW-1:0] n_eff;
    logic [NW-1:0] n_last;
    logic [15:0]   n16;

    // walk step
    logic [AW-1:0] step_cur;
    logic [15:0]   step_nx;
    logic [NW-1:0] steps_inc;
    logic [NW-1:0] freed_inc;
    logic          step_more;
    logic [NW-1:0] free_inc;

    // clear entry
    logic [NW-1:0] clr_ext;
    entry_t        clr_entry;

    vqdfl_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_DESCRIPTORS)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_raw)
    );

    // a size of zero or above the table depth means the whole table
    assign qs_wide = CW'(ring_size_reg);
    assign n_eff   = ((qs_wide == '0) || (qs_wide > CW'(MAX_DESCRIPTORS))) ?
                     NW'(MAX_DESCRIPTORS) : NW'(ring_size_reg);
    assign n_last  = n_eff - NW'(1);
    assign n16     = 16'(n_eff);

    // read data with bypass of a same-address write
    assign rd_eff = fwd_hit_reg ? fwd_data_reg : entry_t'(rd_raw);

    // one free-chain step on the current entry
    assign step_cur  = ctl.walk ? cur_reg : idx_reg[AW-1:0];
    assign step_nx   = rd_eff.next;
    assign steps_inc = (ctl.walk ? steps_reg : '0) + NW'(1);
    assign freed_inc = (ctl.walk ? freed_reg : '0) + NW'(1);
    assign free_inc  = (free_total_reg < n_eff) ? free_total_reg + NW'(1) : free_total_reg;
    assign step_more = ((rd_eff.flags & FLAG_NEXT) != 16'd0) && (steps_inc < n_eff) &&
                       (step_nx < n16);

    // reset contents of the entry under the clear pointer
    assign clr_ext = NW'(clr_addr_reg);
    always_comb
    begin
        clr_entry = '0;
        if (clr_ext < n_last)
        begin
            clr_entry.flags = FLAG_NEXT;
            clr_entry.next  = 16'(clr_addr_reg) + 16'd1;
        end
        else if (clr_ext == n_last)
        begin
            clr_entry.next = LINK_END;
        end
    end

    // read address: list head or index on accept, next link while walking
    always_comb
    begin
        if (ctl.accept)
        begin
            rd_addr = (cmd_t'(cmd) == CMD_ALLOC) ? list_head_reg[AW-1:0] : index[AW-1:0];
        end
        else
        begin
            rd_addr = step_nx[AW-1:0];
        end
    end

    // command execution
    always_comb
    begin
        ring_size_next  = ring_size_reg;
        list_head_next  = list_head_reg;
        free_total_next = free_total_reg;
        clr_addr_next   = clr_addr_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        freed_next      = freed_reg;
        status_next     = status_reg;
        alloc_next      = alloc_reg;
        wr_en           = 1'b0;
        wr_addr         = clr_addr_reg;
        wr_data         = clr_entry;
        stat.walk_more  = 1'b0;
        stat.clear_last = (clr_addr_reg == AW'(MAX_DESCRIPTORS - 1));

        if (ctl.cfg_load)
        begin
            ring_size_next = cfg_data;
            clr_addr_next  = '0;
        end
        else if (ctl.clear)
        begin
            wr_en           = 1'b1;
            clr_addr_next   = clr_addr_reg + AW'(1);
            list_head_next  = 16'd0;
            free_total_next = n_eff;
        end
        else if (ctl.exec || ctl.walk)
        begin
            if (ctl.exec)
            begin
                status_next = ST_OK;
                alloc_next  = 8'd0;
                freed_next  = '0;
            end
            if (ctl.walk || (cmd_reg == CMD_FREE && idx_reg < n16))
            begin
                // push the current entry onto the free list
                wr_en          = 1'b1;
                wr_addr        = step_cur;
                wr_data        = rd_eff;
                wr_data.flags  = FLAG_NEXT;
                wr_data.next   = list_head_reg;
                list_head_next = 16'(step_cur);
                free_total_next = free_inc;
                freed_next     = freed_inc;
                steps_next     = steps_inc;
                cur_next       = step_nx[AW-1:0];
                stat.walk_more = step_more;
            end
            else
            begin
                case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (free_total_reg == '0)
                        begin
                            status_next = ST_NO_FREE;
                        end
                        else if (list_head_reg >= n16)
                        begin
                            status_next     = ST_NO_FREE;
                            free_total_next = '0;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = list_head_reg[AW-1:0];
                            wr_data         = '0;
                            list_head_next  = rd_eff.next;
                            free_total_next = free_total_reg - NW'(1);
                            alloc_next      = 8'(list_head_reg);
                        end
                    end
                    CMD_SET:
                    begin
                        if (idx_reg >= n16)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = idx_reg[AW-1:0];
                            wr_data       = rd_eff;
                            wr_data.addr  = buf_addr_reg;
                            wr_data.len   = buf_len_reg;
                            wr_data.flags = flags_reg;
                        end
                    end
                    CMD_CHAIN:
                    begin
                        if (idx_reg >= n16 || nidx_reg >= n16)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = idx_reg[AW-1:0];
                            wr_data       = rd_eff;
                            wr_data.flags = rd_eff.flags | FLAG_NEXT;
                            wr_data.next  = nidx_reg;
                        end
                    end
                    default:
                    begin
                        // free chain with head out of range
                        status_next = ST_RANGE;
                    end
                endcase
            end
        end
    end

    // bypass when the next read hits the entry being written
    assign fwd_hit_next = wr_en && (rd_addr == wr_addr);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg  <= RING_SIZE_RESET;
            list_head_reg  <= 16'd0;
            free_total_reg <= '0;
            clr_addr_reg   <= '0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            ring_size_reg  <= ring_size_next;
            list_head_reg  <= list_head_next;
            free_total_reg <= free_total_next;
            clr_addr_reg   <= clr_addr_next;
            fwd_hit_reg    <= fwd_hit_next;
        end
    end

    // command latch, walk and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg      <= cmd_t'(cmd);
            idx_reg      <= index;
            nidx_reg     <= next_index;
            buf_addr_reg <= buf_addr;
            buf_len_reg  <= buf_len;
            flags_reg    <= desc_flags_in;
        end
        fwd_data_reg <= wr_data;
        cur_reg      <= cur_next;
        steps_reg    <= steps_next;
        freed_reg    <= freed_next;
        status_reg   <= status_next;
        alloc_reg    <= alloc_next;
    end

    assign status      = status_reg;
    assign alloc_index = alloc_reg;
    assign free_count  = 9'(free_total_reg);
    assign freed_count = 9'(freed_reg);

endmodule

@@ sim/virtqueue_descriptor_free_list_checker.sv @@
`timescale 1ns / 100ps

module virtqueue_descriptor_free_list_checker
    import vqdfl_pkg::*;
#(
    parameter int MAX_DESCRIPTORS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] index,
    input  logic [15:0] next_index,
    input  logic [63:0] buf_addr,
    input  logic [31:0] buf_len,
    input  logic [15:0] desc_flags_in,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [7:0]  alloc_index,
    input  logic [8:0]  free_count,
    input  logic [8:0]  freed_count,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    output int          fail_count,
    output int          results_seen
);

    // one predicted command reply
    typedef struct {
        status_t    st;
        logic [7:0] alloc_idx;
        logic [8:0] free_now;
        logic [8:0] freed;
    } reply_t;

    // shadow descriptor table and free list
    logic [63:0] tbl_addr  [MAX_DESCRIPTORS];
    logic [31:0] tbl_len   [MAX_DESCRIPTORS];
    logic [15:0] tbl_flags [MAX_DESCRIPTORS];
    logic [15:0] tbl_next  [MAX_DESCRIPTORS];
    logic [15:0] head_ptr;
    int          free_cnt;
    logic [8:0]  qsize_reg;

    reply_t expected_replies[$];
    int     mismatches = 0;

    assign fail_count = mismatches;

    function automatic int active_entries();
        if (qsize_reg == 9'd0 || int'(qsize_reg) > MAX_DESCRIPTORS)
            return MAX_DESCRIPTORS;
        return int'(qsize_reg);
    endfunction

    // zero every entry and relink the first n as one free list
    task automatic rebuild_table();
        int n;
        n = active_entries();
        for (int i = 0; i < MAX_DESCRIPTORS; i++)
        begin
            tbl_addr[i]  = '0;
            tbl_len[i]   = '0;
            tbl_flags[i] = '0;
            tbl_next[i]  = '0;
        end
        for (int i = 0; i + 1 < n; i++)
        begin
            tbl_next[i]  = 16'(i + 1);
            tbl_flags[i] = FLAG_NEXT;
        end
        tbl_next[n - 1]  = LINK_END;
        tbl_flags[n - 1] = '0;
        head_ptr = '0;
        free_cnt = n;
    endtask

    // execute one command on the shadow table
    task automatic apply_command(input cmd_t c, input logic [15:0] idx,
                                 input logic [15:0] nidx, input logic [63:0] a,
                                 input logic [31:0] l, input logic [15:0] f,
                                 output reply_t r);
        int n;
        int cur;
        int slot;
        int freed;
        logic [15:0] fl;
        logic [15:0] nx;
        n = active_entries();
        r.st = ST_OK;
        r.alloc_idx = '0;
        freed = 0;
        case (c)
            CMD_ALLOC:
            begin
                if (free_cnt == 0)
                    r.st = ST_NO_FREE;
                else if (int'(head_ptr) >= n)
                begin
                    // head points off the table: count is dropped
                    r.st = ST_NO_FREE;
                    free_cnt = 0;
                end
                else
                begin
                    slot = int'(head_ptr);
                    head_ptr = tbl_next[slot];
                    free_cnt--;
                    tbl_addr[slot]  = '0;
                    tbl_len[slot]   = '0;
                    tbl_flags[slot] = '0;
                    tbl_next[slot]  = '0;
                    r.alloc_idx = 8'(slot);
                end
            end
            CMD_FREE:
            begin
                if (int'(idx) >= n)
                    r.st = ST_RANGE;
                else
                begin
                    // walk the chain, pushing each entry, at most n steps
                    cur = int'(idx);
                    for (int steps = 0; steps < n; steps++)
                    begin
                        if (cur >= n)
                            break;
                        fl = tbl_flags[cur];
                        nx = tbl_next[cur];
                        tbl_next[cur]  = head_ptr;
                        tbl_flags[cur] = FLAG_NEXT;
                        head_ptr = 16'(cur);
                        if (free_cnt < n)
                            free_cnt++;
                        freed++;
                        if ((fl & FLAG_NEXT) == '0)
                            break;
                        cur = int'(nx);
                    end
                end
            end
            CMD_SET:
            begin
                if (int'(idx) >= n)
                    r.st = ST_RANGE;
                else
                begin
                    tbl_addr[idx]  = a;
                    tbl_len[idx]   = l;
                    tbl_flags[idx] = f;
                end
            end
            default:
            begin
                if (int'(idx) >= n || int'(nidx) >= n)
                    r.st = ST_RANGE;
                else
                begin
                    tbl_next[idx]  = nidx;
                    tbl_flags[idx] = tbl_flags[idx] | FLAG_NEXT;
                end
            end
        endcase
        r.free_now = 9'(free_cnt);
        r.freed    = 9'(freed);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // compare a strobed result with the oldest prediction
    task automatic check_reply();
        reply_t want;
        if (expected_replies.size() == 0)
        begin
            report_mismatch("result with no command outstanding", 64'(status), 64'd0);
            return;
        end
        want = expected_replies.pop_front();
        if (status !== want.st)
            report_mismatch("status", 64'(status), 64'(want.st));
        if (alloc_index !== want.alloc_idx)
            report_mismatch("alloc_index", 64'(alloc_index), 64'(want.alloc_idx));
        if (free_count !== want.free_now)
            report_mismatch("free_count", 64'(free_count), 64'(want.free_now));
        if (freed_count !== want.freed)
            report_mismatch("freed_count", 64'(freed_count), 64'(want.freed));
    endtask

    // observe result, config and command transfers in that order
    always @(posedge clk or negedge rst_n)
    begin
        reply_t r;
        if (!rst_n)
        begin
            qsize_reg = RING_SIZE_RESET;
            rebuild_table();
            expected_replies.delete();
            results_seen <= 0;
        end
        else
        begin
            if (done)
            begin
                check_reply();
                results_seen <= results_seen + 1;
            end
            if (cfg_valid && cfg_ready)
            begin
                qsize_reg = cfg_data;
                rebuild_table();
            end
            if (start && !busy)
            begin
                apply_command(cmd_t'(cmd), index, next_index, buf_addr, buf_len,
                              desc_flags_in, r);
                expected_replies.push_back(r);
            end
        end
    end

endmodule

@@ sim/tb_virtqueue_descriptor_free_list_top.sv @@
`timescale 1ns / 100ps

module tb_virtqueue_descriptor_free_list_top
    import vqdfl_pkg::*;
;

    localparam int MAXD       = 256;
    localparam int IDLE_LIMIT = 3000;
    localparam int PHASE_LEN  = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  cmd = '0;
    logic [15:0] index = '0;
    logic [15:0] next_index = '0;
    logic [63:0] buf_addr = '0;
    logic [31:0] buf_len = '0;
    logic [15:0] desc_flags_in = '0;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  alloc_index;
    logic [8:0]  free_count;
    logic [8:0]  freed_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;

    int fail_count;
    int results_seen;
    int items_sent = 0;
    int burst_left = 0;
    int cur_size = MAXD;
    int idle_cycles = 0;

    virtqueue_descriptor_free_list_top #(
        .MAX_DESCRIPTORS(MAXD)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .index(index),
        .next_index(next_index),
        .buf_addr(buf_addr),
        .buf_len(buf_len),
        .desc_flags_in(desc_flags_in),
        .done(done),
        .status(status),
        .alloc_index(alloc_index),
        .free_count(free_count),
        .freed_count(freed_count),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    virtqueue_descriptor_free_list_checker #(
        .MAX_DESCRIPTORS(MAXD)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .index(index),
        .next_index(next_index),
        .buf_addr(buf_addr),
        .buf_len(buf_len),
        .desc_flags_in(desc_flags_in),
        .done(done),
        .status(status),
        .alloc_index(alloc_index),
        .free_count(free_count),
        .freed_count(freed_count),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .results_seen(results_seen)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || (cfg_valid && cfg_ready) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic int size_used(input logic [8:0] v);
        if (v == 9'd0 || int'(v) > MAXD)
            return MAXD;
        return int'(v);
    endfunction

    // mostly in range, some at the boundary, some anywhere in 16 bits
    function automatic logic [15:0] pick_index(input int n);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 16'($urandom_range(0, n - 1));
        if (r < 8)
            return 16'(n - 1 + $urandom_range(0, 1));
        return 16'($urandom);
    endfunction

    // one command transfer, sender idles in bursts with gaps
    task automatic issue(input cmd_t c, input logic [15:0] i, input logic [15:0] ni,
                         input logic [63:0] a, input logic [31:0] l,
                         input logic [15:0] f);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 10);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(30, 60);
            else
                burst_left = $urandom_range(1, 12);
        end
        start         <= 1'b1;
        cmd           <= c;
        index         <= i;
        next_index    <= ni;
        buf_addr      <= a;
        buf_len       <= l;
        desc_flags_in <= f;
        do @(posedge clk); while (busy);
        burst_left--;
        items_sent++;
    endtask

    // hold off until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        while (results_seen < items_sent) @(posedge clk);
    endtask

    task automatic write_qsize(input logic [8:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_size = size_used(v);
    endtask

    task automatic random_command(input int n);
        issue(cmd_t'($urandom_range(0, 3)), pick_index(n), pick_index(n),
              {$urandom, $urandom}, $urandom, 16'($urandom));
    endtask

    // allocate a few, fill and link k entries, then free the chain
    task automatic chain_round(input int n, inout int count);
        int k;
        int na;
        logic [15:0] picks [6];
        logic [15:0] fl;
        k = $urandom_range(1, (n < 6) ? n : 6);
        na = $urandom_range(0, k);
        for (int j = 0; j < na; j++)
        begin
            issue(CMD_ALLOC, 16'($urandom), 16'($urandom), {$urandom, $urandom},
                  $urandom, 16'($urandom));
            count++;
        end
        for (int j = 0; j < k; j++)
            picks[j] = 16'($urandom_range(0, n - 1));
        for (int j = 0; j < k; j++)
        begin
            fl = 16'($urandom);
            if (j < k - 1)
                fl = fl | FLAG_NEXT;
            issue(CMD_SET, picks[j], 16'($urandom), {$urandom, $urandom}, $urandom, fl);
            count++;
        end
        for (int j = 0; j + 1 < k; j++)
        begin
            issue(CMD_CHAIN, picks[j], picks[j + 1], {$urandom, $urandom}, $urandom,
                  16'($urandom));
            count++;
        end
        issue(CMD_FREE, picks[0], 16'($urandom), {$urandom, $urandom}, $urandom,
              16'($urandom));
        count++;
    endtask

    logic [8:0] phase_sizes [11] = '{9'd1, 9'd2, 9'd0, 9'd8, 9'd511, 9'd16, 9'd300,
                                     9'd5, 9'd256, 9'd64, 9'd3};

    initial
    begin
        int count;
        bit paused;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // edges at the reset size
        issue(CMD_ALLOC, 16'd0, 16'd0, '0, '0, '0);
        issue(CMD_SET, 16'd0, 16'hFFFF, '1, '1, 16'hFFFF);
        issue(CMD_SET, 16'd255, 16'd0, '0, '0, '0);
        issue(CMD_SET, 16'd256, 16'd0, '1, '1, '1);
        issue(CMD_SET, 16'hFFFF, 16'hFFFF, '1, '0, '1);
        issue(CMD_CHAIN, 16'd0, 16'd255, '0, '0, '0);
        issue(CMD_CHAIN, 16'd0, 16'd256, '0, '0, '0);
        issue(CMD_CHAIN, 16'hFFFF, 16'd0, '0, '0, '0);
        // short chain freed into a full list: count saturates
        issue(CMD_FREE, 16'd0, 16'd0, '0, '0, '0);
        issue(CMD_FREE, 16'd256, 16'd0, '0, '0, '0);
        issue(CMD_FREE, 16'hFFFF, 16'd0, '0, '0, '0);
        drain();

        // four entries: empty list, then a looping chain that leaves a broken head
        write_qsize(9'd4);
        repeat (5) issue(CMD_ALLOC, '0, '0, '0, '0, '0);
        issue(CMD_CHAIN, 16'd0, 16'd1, '0, '0, '0);
        issue(CMD_CHAIN, 16'd1, 16'd2, '0, '0, '0);
        issue(CMD_CHAIN, 16'd2, 16'd2, '0, '0, '0);
        issue(CMD_FREE, 16'd0, 16'd0, '0, '0, '0);
        repeat (4) issue(CMD_ALLOC, '0, '0, '0, '0, '0);
        drain();

        // random phases over several queue sizes
        foreach (phase_sizes[p])
        begin
            write_qsize(phase_sizes[p]);
            count = 0;
            paused = 1'b0;
            while (count < PHASE_LEN)
            begin
                if (!paused && count >= PHASE_LEN / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 9) < 6)
                    chain_round(cur_size, count);
                else
                begin
                    random_command(cur_size);
                    count++;
                end
            end
            drain();
        end

        // catch stray strobes after the last result
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
